>>> design/two_wheel_flap_stepper_controller_defines.svh
// ----------------------------------------------------------------------------
// two_wheel_flap_stepper_controller_defines
// assertion macros used by the checker file of the flap stepper controller
// ----------------------------------------------------------------------------
`ifndef TWO_WHEEL_FLAP_STEPPER_CONTROLLER_DEFINES_SVH
`define TWO_WHEEL_FLAP_STEPPER_CONTROLLER_DEFINES_SVH

// property checked at every clock edge, reset included
`define TWFS_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// property checked only while reset is low
`define TWFS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> design/twfs_pkg.sv
// ----------------------------------------------------------------------------
// twfs_pkg
// types and constants of the two-wheel flap stepper controller
// ----------------------------------------------------------------------------
`default_nettype none

package twfs_pkg;

   localparam int CMD_W      = 2;
   localparam int STEP_W     = 16;
   localparam int PHASE_W    = 2;
   localparam int DEBOUNCE_W = 4;
   localparam int COIL_W     = 8;
   localparam int HOMING_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [STEP_W-1:0] FLAP_STEPS_RST            = 16'd202;
   localparam logic [STEP_W-1:0] UNIT_HOME_OFFSET_RST      = 16'd120;
   localparam logic [STEP_W-1:0] TICKS_PER_DAY_RST         = 16'd10800;
   localparam logic [STEP_W-1:0] TENS_FIRST_HOME_STEPS_RST = 16'd1940;
   localparam logic [STEP_W-1:0] TENS_REHOME_STEPS_RST     = 16'd100;
   localparam logic [STEP_W-1:0] FULL_TURN_STEPS_RST       = 16'd2048;

   // state reset values
   localparam logic [STEP_W-1:0]     REMAINING_RST      = 16'd2048;
   localparam logic [HOMING_W-1:0]   HOMING_RST         = 2'b11;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX       = 4'd15;
   localparam logic [DEBOUNCE_W-1:0] RESET_DEBOUNCE_RST = DEBOUNCE_MAX;

   typedef enum logic [CMD_W-1:0] {
      CMD_STEP_TICK  = 2'd0,
      CMD_DAY_TICK   = 2'd1,
      CMD_UNITS_HOME = 2'd2,
      CMD_TENS_HOME  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLAP_STEPS            = 3'd0,
      CSR_UNIT_HOME_OFFSET      = 3'd1,
      CSR_TICKS_PER_DAY         = 3'd2,
      CSR_TENS_FIRST_HOME_STEPS = 3'd3,
      CSR_TENS_REHOME_STEPS     = 3'd4,
      CSR_FULL_TURN_STEPS       = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [STEP_W-1:0] flap_steps;
      logic [STEP_W-1:0] unit_home_offset;
      logic [STEP_W-1:0] ticks_per_day;
      logic [STEP_W-1:0] tens_first_home_steps;
      logic [STEP_W-1:0] tens_rehome_steps;
      logic [STEP_W-1:0] full_turn_steps;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0]    units_phase;
      logic [PHASE_W-1:0]    tens_phase;
      logic [STEP_W-1:0]     units_remaining;
      logic [STEP_W-1:0]     tens_remaining;
      logic [STEP_W-1:0]     day_tick_count;
      logic [HOMING_W-1:0]   homing_pending;
      logic [DEBOUNCE_W-1:0] reset_debounce;
      logic [DEBOUNCE_W-1:0] advance_debounce;
      logic [COIL_W-1:0]     coil_register;
      logic                  lamp_on;
   } state_type;

endpackage

`default_nettype wire

>>> design/two_wheel_flap_stepper_controller.sv
// ----------------------------------------------------------------------------
// two_wheel_flap_stepper_controller
// Split-flap day counter controller: two four-phase steppers, button
// debounce, homing and the carry from the units wheel into the tens wheel.
//
// Usage:
//  - req_* channel (valid/ready) carries one event: step tick with both
//    button levels, day tick, units home switch or tens home switch.
//  - rsp_* channel (valid/ready) returns one transaction per event with the
//    coil drive, carry lamp, remaining steps and homing flags after it.
//  - csr_* is a write-only port, one register per cycle, index 0 to 5;
//    indexes 6 and 7 are ignored. Write only while no event is in flight.
//  - An event is taken into an input register, then the state update and
//    the result are computed in one pass into the result register: rsp_valid
//    rises once the event leaves the input register for the result register.
//  - Throughput is one event per cycle while rsp_ready is high; the state
//    register feeds straight back into the next-state logic, so events never wait.
//  - A stalled rsp_ready holds the result; the input register still takes
//    one more event, after which req_ready drops until the result leaves.
//  - Synchronous reset loads the register defaults, both wheels with 2048
//    steps, both homing flags set and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wheel_flap_stepper_controller (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [twfs_pkg::CMD_W-1:0]       req_command,
   input  logic                             req_reset_button_high,
   input  logic                             req_advance_button_high,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [twfs_pkg::COIL_W-1:0]      rsp_coil_drive,
   output logic                             rsp_carry_lamp,
   output logic [twfs_pkg::STEP_W-1:0]      rsp_units_left,
   output logic [twfs_pkg::STEP_W-1:0]      rsp_tens_left,
   output logic [twfs_pkg::HOMING_W-1:0]    rsp_homing_flags,

   input  logic                             csr_we,
   input  logic [twfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import twfs_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   state_type state_nxt;

   logic      in_valid_ff;
   logic      in_valid_in;
   cmd_type   in_cmd_ff;
   logic      in_rst_high_ff;
   logic      in_adv_high_ff;

   logic      out_valid_ff;
   logic      out_valid_in;
   logic      advance;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_FLAP_STEPS:            cfg_in.flap_steps            = csr_wdata;
            CSR_UNIT_HOME_OFFSET:      cfg_in.unit_home_offset      = csr_wdata;
            CSR_TICKS_PER_DAY:         cfg_in.ticks_per_day         = csr_wdata;
            CSR_TENS_FIRST_HOME_STEPS: cfg_in.tens_first_home_steps = csr_wdata;
            CSR_TENS_REHOME_STEPS:     cfg_in.tens_rehome_steps     = csr_wdata;
            CSR_FULL_TURN_STEPS:       cfg_in.full_turn_steps       = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flap_steps            <= FLAP_STEPS_RST;
         cfg_ff.unit_home_offset      <= UNIT_HOME_OFFSET_RST;
         cfg_ff.ticks_per_day         <= TICKS_PER_DAY_RST;
         cfg_ff.tens_first_home_steps <= TENS_FIRST_HOME_STEPS_RST;
         cfg_ff.tens_rehome_steps     <= TENS_REHOME_STEPS_RST;
         cfg_ff.full_turn_steps       <= FULL_TURN_STEPS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // handshake: input register, then result register
   // ---------------------------------------------------------------------
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff      <= cmd_type'(req_command);
         in_rst_high_ff <= req_reset_button_high;
         in_adv_high_ff <= req_advance_button_high;
      end
   end

   // ---------------------------------------------------------------------
   // controller state
   // ---------------------------------------------------------------------
   twfs_core u_core (
      .state_cur           (state_ff),
      .cfg                 (cfg_ff),
      .command             (in_cmd_ff),
      .reset_button_high   (in_rst_high_ff),
      .advance_button_high (in_adv_high_ff),
      .state_nxt           (state_nxt)
   );

   assign state_in = advance ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.units_phase      <= '0;
         state_ff.tens_phase       <= '0;
         state_ff.units_remaining  <= REMAINING_RST;
         state_ff.tens_remaining   <= REMAINING_RST;
         state_ff.day_tick_count   <= '0;
         state_ff.homing_pending   <= HOMING_RST;
         state_ff.reset_debounce   <= RESET_DEBOUNCE_RST;
         state_ff.advance_debounce <= '0;
         state_ff.coil_register    <= '0;
         state_ff.lamp_on          <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_coil_drive   <= state_nxt.coil_register;
         rsp_carry_lamp   <= state_nxt.lamp_on;
         rsp_units_left   <= state_nxt.units_remaining;
         rsp_tens_left    <= state_nxt.tens_remaining;
         rsp_homing_flags <= state_nxt.homing_pending;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

>>> design/twfs_core.sv
// ----------------------------------------------------------------------------
// twfs_core
// next-state logic: applies one event to the controller state
// ----------------------------------------------------------------------------
`default_nettype none

module twfs_core (
   input  twfs_pkg::state_type state_cur,
   input  twfs_pkg::cfg_type   cfg,
   input  twfs_pkg::cmd_type   command,
   input  logic                reset_button_high,
   input  logic                advance_button_high,
   output twfs_pkg::state_type state_nxt
);
   import twfs_pkg::*;

   state_type             s;
   logic [DEBOUNCE_W-1:0] rst_dbn;
   logic [DEBOUNCE_W-1:0] adv_dbn;
   logic [STEP_W-1:0]     day_cnt;

   always_comb begin
      s       = state_cur;
      rst_dbn = state_cur.reset_debounce;
      adv_dbn = state_cur.advance_debounce;
      day_cnt = state_cur.day_tick_count + STEP_W'(1);

      case (command)
         CMD_STEP_TICK: begin
            // reset button: re-home when the counter runs down to zero
            if (reset_button_high) begin
               if (rst_dbn != DEBOUNCE_MAX) rst_dbn = rst_dbn + DEBOUNCE_W'(1);
            end else if (rst_dbn != '0) begin
               rst_dbn = rst_dbn - DEBOUNCE_W'(1);
               if (rst_dbn == '0) begin
                  s.homing_pending  = HOMING_RST;
                  s.units_remaining = cfg.full_turn_steps;
                  s.tens_remaining  = cfg.full_turn_steps;
                  s.day_tick_count  = '0;
               end
            end
            s.reset_debounce = rst_dbn;

            // advance button: one extra flap on the units wheel
            if (advance_button_high) begin
               if (adv_dbn != DEBOUNCE_MAX) adv_dbn = adv_dbn + DEBOUNCE_W'(1);
            end else if (adv_dbn != '0) begin
               adv_dbn = adv_dbn - DEBOUNCE_W'(1);
               if (adv_dbn == '0) begin
                  s.units_remaining = s.units_remaining + cfg.flap_steps;
               end
            end
            s.advance_debounce = adv_dbn;

            // phases run backwards, one coil at a time
            if (s.units_remaining != '0) begin
               s.units_remaining        = s.units_remaining - STEP_W'(1);
               s.units_phase            = s.units_phase - PHASE_W'(1);
               s.coil_register[3:0]     = 4'b0001 << s.units_phase;
            end else begin
               s.coil_register[3:0]     = '0;
            end

            if (s.tens_remaining != '0) begin
               s.tens_remaining         = s.tens_remaining - STEP_W'(1);
               s.tens_phase             = s.tens_phase - PHASE_W'(1);
               s.coil_register[7:4]     = 4'b0001 << s.tens_phase;
            end else begin
               s.coil_register[7:4]     = '0;
               s.lamp_on                = 1'b0;
            end
         end

         CMD_DAY_TICK: begin
            if (day_cnt >= cfg.ticks_per_day) begin
               s.day_tick_count  = '0;
               s.units_remaining = cfg.flap_steps;
            end else begin
               s.day_tick_count  = day_cnt;
            end
         end

         CMD_UNITS_HOME: begin
            s.homing_pending[0] = 1'b0;
            s.units_remaining   = cfg.unit_home_offset;
            // carry into the tens wheel once it has homed and stands still
            if (!state_cur.homing_pending[1] && (state_cur.tens_remaining == '0)) begin
               s.tens_remaining = cfg.flap_steps;
               s.lamp_on        = 1'b1;
            end
         end

         CMD_TENS_HOME: begin
            if (state_cur.homing_pending[1]) begin
               s.homing_pending[1] = 1'b0;
               s.tens_remaining    = cfg.tens_first_home_steps;
            end else begin
               s.tens_remaining    = cfg.tens_rehome_steps;
            end
         end

         default: begin
            s = state_cur;
         end
      endcase
   end

   assign state_nxt = s;

endmodule

`default_nettype wire

>>> design/twfs_checker.sv
// ----------------------------------------------------------------------------
// twfs_checker
// port-level checks on the flap stepper controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_wheel_flap_stepper_controller_defines.svh"

module twfs_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [twfs_pkg::COIL_W-1:0]      rsp_coil_drive,
   input  logic                             rsp_carry_lamp,
   input  logic [twfs_pkg::STEP_W-1:0]      rsp_units_left,
   input  logic [twfs_pkg::STEP_W-1:0]      rsp_tens_left,
   input  logic [twfs_pkg::HOMING_W-1:0]    rsp_homing_flags
);

   // a stalled result holds
   `TWFS_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coil_drive) && $stable(rsp_carry_lamp) && $stable(rsp_units_left) && $stable(rsp_tens_left) && $stable(rsp_homing_flags), "stalled result transaction changed")

   // at most one coil per wheel
   `TWFS_ASSERT_RST(a_coil_onehot, clock, reset, rsp_valid |-> $onehot0(rsp_coil_drive[3:0]) && $onehot0(rsp_coil_drive[7:4]), "more than one coil driven on a wheel")

   // input side only backs off while the result side is stalled
   `TWFS_ASSERT_RST(a_ready_stall, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "req_ready low without a stalled result")

   // reset empties the result register
   `TWFS_ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind two_wheel_flap_stepper_controller twfs_checker u_twfs_checker (.*);

`default_nettype wire
